@@ hdl/mdps_pkg.sv @@
// Shared constants, types and helpers for the point suppression block.
package mdps_pkg;
	localparam int MAX_KEPT_DEF   = 1024;
	localparam int COORD_BITS_DEF = 12;
	localparam int MIND_W         = 8;
	localparam int MAXC_W         = 11;
	localparam int VERD_W         = 2;
	localparam int BANKS          = 4;
	localparam int FIFO_DEPTH     = 2;

	localparam logic [VERD_W-1:0] V_KEPT  = 2'd0;
	localparam logic [VERD_W-1:0] V_CLOSE = 2'd1;
	localparam logic [VERD_W-1:0] V_LIMIT = 2'd2;
	localparam logic [VERD_W-1:0] V_FULL  = 2'd3;

	localparam logic REG_MIN_DIST = 1'b0;
	localparam logic REG_MAX_CORN = 1'b1;
endpackage

@@ hdl/mdps_fifo.sv @@
// Small queue of accepted input beats between front and back.
module mdps_fifo import mdps_pkg::*; #(
	parameter int W = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] mem_q [FIFO_DEPTH];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'(FIFO_DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule

@@ hdl/mdps_judge.sv @@
// Back end: searches kept points over banked memory and forms the verdict.
module mdps_judge import mdps_pkg::*; #(
	parameter int MAX_KEPT   = MAX_KEPT_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [MIND_W-1:0]     min_distance,
	input  logic [MAXC_W-1:0]     max_corners,
	input  logic                  in_valid,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	input  logic                  in_last,
	output logic                  in_take,
	output logic                  res_valid,
	input  logic                  res_take,
	output logic                  kept,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [VERD_W-1:0]     verdict,
	output logic [MAXC_W-1:0]     kept_total,
	output logic                  set_end
);
	localparam int CW    = $clog2(MAX_KEPT + 1);
	localparam int KW    = (CW > MAXC_W) ? CW : MAXC_W;
	localparam int BD    = MAX_KEPT / BANKS;
	localparam int BAW   = $clog2(BD);
	localparam int BSW   = $clog2(BANKS);
	localparam int DW    = COORD_BITS + 1;
	localparam int SQW   = 2 * COORD_BITS + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            st_q;
	logic [CW-1:0]         count_q;
	logic [BAW:0]          raddr_q;
	logic [BAW:0]          rows;
	logic                  rv_s1;
	logic [BAW:0]          row_s1;
	logic [BANKS-1:0]      hit;
	logic [BANKS-1:0]      pv_s2;
	logic [SQW-1:0]        sq_s2 [BANKS];
	logic                  close_q;
	logic [2*MIND_W-1:0]   lim_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic                  last_q;
	logic [2*COORD_BITS-1:0] xr_s1 [BANKS];
	logic [2*COORD_BITS-1:0] bank_q [BANKS][BD];
	logic                  out_v_q;
	logic                  ofree;
	logic                  lim_hit, store_full, scan_go;

	assign rows  = (BAW+1)'((count_q + CW'(BANKS - 1)) >> BSW);
	assign ofree = !out_v_q || res_take;
	assign in_take   = (st_q == ST_IDLE) && in_valid;
	assign res_valid = out_v_q;
	assign lim_hit    = (max_corners != '0) && (KW'(count_q) >= KW'(max_corners));
	assign store_full = count_q >= CW'(MAX_KEPT);
	assign scan_go    = (raddr_q < rows) && (min_distance != '0) && !lim_hit && !store_full;

	genvar b;
	generate
		for (b = 0; b < BANKS; b++) begin : g_bank
			logic [DW-1:0] dx, dy;
			always_ff @(posedge clk) begin
				xr_s1[b] <= bank_q[b][raddr_q[BAW-1:0]];
				if (st_q == ST_DONE && ofree && !close_q && !lim_hit && !store_full
						&& count_q[BSW-1:0] == BSW'(b))
					bank_q[b][count_q[BAW+BSW-1:BSW]] <= {x_q, y_q};
			end
			assign dx = (x_q > xr_s1[b][2*COORD_BITS-1:COORD_BITS])
				? DW'(x_q - xr_s1[b][2*COORD_BITS-1:COORD_BITS])
				: DW'(xr_s1[b][2*COORD_BITS-1:COORD_BITS] - x_q);
			assign dy = (y_q > xr_s1[b][COORD_BITS-1:0])
				? DW'(y_q - xr_s1[b][COORD_BITS-1:0])
				: DW'(xr_s1[b][COORD_BITS-1:0] - y_q);
			always_ff @(posedge clk) begin
				sq_s2[b] <= SQW'(dx) * SQW'(dx) + SQW'(dy) * SQW'(dy);
				pv_s2[b] <= rv_s1 && ({row_s1, BSW'(b)} < (BAW+1+BSW)'(count_q));
			end
			assign hit[b] = pv_s2[b] && (sq_s2[b] < SQW'(lim_q));
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= in_x; y_q <= in_y; last_q <= in_last;
			lim_q <= min_distance * min_distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; count_q <= '0; raddr_q <= '0;
			rv_s1 <= 1'b0; row_s1 <= '0; close_q <= 1'b0; out_v_q <= 1'b0;
			kept <= 1'b0; out_x <= '0; out_y <= '0; verdict <= V_KEPT;
			kept_total <= '0; set_end <= 1'b0;
		end else begin
			out_v_q <= (out_v_q && !res_take) || (st_q == ST_DONE && ofree);
			rv_s1 <= (st_q == ST_SCAN) && scan_go;
			case (st_q)
				ST_IDLE: begin
					if (in_take) begin
						st_q <= ST_SCAN; raddr_q <= '0; close_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (|hit) close_q <= 1'b1;
					if (scan_go) begin
						row_s1 <= raddr_q; raddr_q <= raddr_q + 1'b1;
					end else if (!rv_s1 && pv_s2 == '0) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ofree) begin
						out_x <= x_q; out_y <= y_q; set_end <= last_q;
						if (lim_hit) begin
							verdict <= V_LIMIT; kept <= 1'b0;
							kept_total <= MAXC_W'(count_q);
						end else if (store_full) begin
							verdict <= V_FULL; kept <= 1'b0;
							kept_total <= MAXC_W'(count_q);
						end else if (close_q) begin
							verdict <= V_CLOSE; kept <= 1'b0;
							kept_total <= MAXC_W'(count_q);
						end else begin
							verdict <= V_KEPT; kept <= 1'b1;
							kept_total <= MAXC_W'(count_q + 1'b1);
						end
						if (last_q) count_q <= '0;
						else if (!close_q && !lim_hit && !store_full)
							count_q <= count_q + 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/min_distance_point_suppression.sv @@
// Top level: minimum distance suppression of sorted feature points.
//  channel   | handshake         | payload
//  input     | push / full       | point_x, point_y, last_point
//  result    | pop / empty       | kept, out_x, out_y, verdict, kept_total, set_end
//  config    | cfg_valid / ready | cfg_index, cfg_data
// The back end searches the kept points by reading four memory banks per cycle;
// points with suppression off or refused skip the search.
// Reset clears counts and queues; the point store needs no clearing.
// A full result register stalls the back end; the input queue keeps taking beats until it is full.
module min_distance_point_suppression import mdps_pkg::*; #(
	parameter int MAX_KEPT   = MAX_KEPT_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic                  last_point,
	output logic                  empty,
	input  logic                  pop,
	output logic                  kept,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [VERD_W-1:0]     verdict,
	output logic [MAXC_W-1:0]     kept_total,
	output logic                  set_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [MAXC_W-1:0]     cfg_data
);
	localparam int FW = 2 * COORD_BITS + 1;
	logic [MIND_W-1:0] mind_q;
	logic [MAXC_W-1:0] max_corn_q;
	logic [FW-1:0]     qd;
	logic              qempty, take, rvalid;

	assign cfg_ready = 1'b1;
	assign empty = !rvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mind_q <= '0; max_corn_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_DIST: mind_q <= cfg_data[MIND_W-1:0];
				REG_MAX_CORN: max_corn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mdps_fifo #(.W(FW)) u_fifo (
		.clk, .arst_n, .wr(push), .wdata({point_x, point_y, last_point}), .full,
		.rd(take), .rdata(qd), .empty(qempty)
	);

	mdps_judge #(.MAX_KEPT(MAX_KEPT), .COORD_BITS(COORD_BITS)) u_judge (
		.clk, .arst_n, .min_distance(mind_q), .max_corners(max_corn_q),
		.in_valid(!qempty), .in_x(qd[FW-1:COORD_BITS+1]), .in_y(qd[COORD_BITS:1]),
		.in_last(qd[0]), .in_take(take), .res_valid(rvalid), .res_take(pop && rvalid),
		.kept, .out_x, .out_y, .verdict, .kept_total, .set_end
	);
endmodule

@@ test/testbench.sv @@
// Testbench for the minimum distance point suppression block.
`timescale 1ns / 100ps

class suppression_scoreboard;
	bit [11:0] kept_x_mem[1024];
	bit [11:0] kept_y_mem[1024];
	int unsigned kept_cnt;
	bit [7:0] dist_thr;
	bit [10:0] max_corn;
	bit [38:0] pending_q[$];
	int unsigned mismatches;

	function void clear();
		kept_cnt = 0;
		dist_thr = 0;
		max_corn = 0;
		mismatches = 0;
	endfunction

	function void write_reg(logic idx, bit [10:0] data);
		if (idx == mdps_pkg::REG_MIN_DIST)
			dist_thr = data[7:0];
		else
			max_corn = data;
	endfunction

	function void note_point(bit [11:0] x, bit [11:0] y, bit last);
		bit [1:0] v;
		bit close;
		longint lim, dx, dy;
		lim = longint'(dist_thr) * dist_thr;
		close = 0;
		if (max_corn != 0 && kept_cnt >= max_corn)
			v = mdps_pkg::V_LIMIT;
		else if (kept_cnt >= 1024)
			v = mdps_pkg::V_FULL;
		else begin
			if (dist_thr != 0)
				for (int i = 0; i < kept_cnt; i++) begin
					dx = longint'(x) - kept_x_mem[i];
					dy = longint'(y) - kept_y_mem[i];
					if (dx * dx + dy * dy < lim)
						close = 1;
				end
			if (close)
				v = mdps_pkg::V_CLOSE;
			else begin
				kept_x_mem[kept_cnt] = x;
				kept_y_mem[kept_cnt] = y;
				kept_cnt++;
				v = mdps_pkg::V_KEPT;
			end
		end
		pending_q.insert(pending_q.size(),
			{v == mdps_pkg::V_KEPT, x, y, v, kept_cnt[10:0], last});
		if (last)
			kept_cnt = 0;
	endfunction

	function void check_result(bit [38:0] got);
		bit [38:0] exp;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", got);
			return;
		end
		exp = pending_q.pop_front();
		if (exp !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: exp kept=%0d x=%0d y=%0d v=%0d tot=%0d end=%0d,",
					" got kept=%0d x=%0d y=%0d v=%0d tot=%0d end=%0d"},
					exp[38], exp[37:26], exp[25:14], exp[13:12], exp[11:1], exp[0],
					got[38], got[37:26], got[25:14], got[13:12], got[11:1], got[0]);
		end
	endfunction
endclass

module testbench;
	import mdps_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic [11:0] point_x = 0;
	logic [11:0] point_y = 0;
	logic last_point = 0;
	logic pop = 0;
	logic cfg_valid = 0;
	logic cfg_index = 0;
	logic [10:0] cfg_data = 0;
	logic full, empty, kept, set_end, cfg_ready;
	logic [11:0] out_x, out_y;
	logic [1:0] verdict;
	logic [10:0] kept_total;

	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int quiet_cycles = 0;
	suppression_scoreboard sb = new();

	min_distance_point_suppression dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (!empty && pop)
				sb.check_result({kept, out_x, out_y, verdict, kept_total, set_end});
			if ((push && !full) || (!empty && pop) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	always @(posedge clk)
		if (quiet_cycles > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end

	task automatic write_cfg(logic idx, bit [10:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_point(bit [11:0] x, bit [11:0] y, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		do @(posedge clk); while (full);
		sb.note_point(x, y, last);
	endtask

	task automatic drain();
		push <= 0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_set(int n, int span);
		bit [11:0] bx, by;
		bx = 12'($urandom);
		by = 12'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_point(12'($urandom), 12'($urandom), 1'($urandom_range(1)));
			else
				send_point(12'(bx + $urandom_range(span)), 12'(by + $urandom_range(span)),
					i == n - 1);
		end
	endtask

	initial begin
		int phase_idle[4] = '{0, 78, 0, 17};
		int phase_stall[4] = '{0, 0, 78, 17};
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, suppression off, too close, limit
		send_point(0, 0, 0);
		send_point(12'hFFF, 12'hFFF, 0);
		send_point(0, 0, 1);
		drain();
		write_cfg(REG_MIN_DIST, 10);
		write_cfg(REG_MAX_CORN, 3);
		send_point(100, 100, 0);
		send_point(106, 108, 0);
		send_point(105, 107, 0);
		send_point(200, 100, 0);
		send_point(300, 100, 0);
		send_point(400, 100, 1);
		send_point(12'hFFF, 0, 0);
		send_point(0, 12'hFFF, 1);
		drain();
		write_cfg(REG_MIN_DIST, 255);
		write_cfg(REG_MAX_CORN, 1024);
		send_point(0, 0, 0);
		send_point(254, 0, 0);
		send_point(255, 0, 0);
		send_point(12'hFFF, 12'hFFF, 1);
		drain();

		// fill the store past its capacity with suppression off
		write_cfg(REG_MIN_DIST, 0);
		write_cfg(REG_MAX_CORN, 0);
		for (int i = 0; i < 1030; i++)
			send_point(12'($urandom), 12'($urandom), i == 1029);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			pop_stall_pct = phase_stall[p];
			write_cfg(REG_MIN_DIST, 11'(p == 0 ? 1 : $urandom_range(2, 40)));
			write_cfg(REG_MAX_CORN, 11'(p == 1 ? 2047 : $urandom_range(0, 40)));
			for (int s = 0; s < 2; s++)
				random_set($urandom_range(1, 40), $urandom_range(10, 300));
			drain();
		end
		write_cfg(REG_MIN_DIST, 255);
		write_cfg(REG_MAX_CORN, 1);
		random_set(5, 4095);
		drain();

		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
